[rtl/box_downsample_4x4_assert.svh]
// assertion macros shared by the checker of box_downsample_4x4
// no dependencies; the including module supplies clock and reset names
`ifndef BOX_DOWNSAMPLE_4X4_ASSERT_SVH
`define BOX_DOWNSAMPLE_4X4_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define BD4_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define BD4_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bd4_pkg.sv]
// types and constants for the 4x4 box downsampler
// no dependencies
`timescale 1ns / 1ps

package bd4_pkg;

    localparam int PIX_W      = 8;
    localparam int HSUM_W     = 10;
    localparam int SUM_W      = 12;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam logic [CFG_W-1:0] ROW_LIMIT = 11'd1024;
    localparam logic [CFG_W-1:0] MIN_DIM   = 11'd4;
    localparam logic [CFG_W-1:0] RESET_DIM = 11'd28;

    // configuration register indexes
    localparam logic [0:0] REG_ROW_BYTES  = 1'b0;
    localparam logic [0:0] REG_IMAGE_ROWS = 1'b1;

    // one finished four-pixel group handed from front to back
    typedef struct packed {
        logic              first_row;
        logic              emit;
        logic              end_row;
        logic              end_frame;
        logic [HSUM_W-1:0] hsum;
    } blk_op_t;

endpackage

[rtl/bd4_fifo.sv]
// short word queue between the front and back parts
// depends on bd4_pkg
`timescale 1ns / 1ps

module bd4_fifo
    import bd4_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    input  logic          pop,
    output logic [DW-1:0] rdata,
    output logic          full,
    output logic          empty
);

    logic [DW-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg, wptr_next;
    logic [FIFO_PTR_W-1:0] rptr_reg, rptr_next;
    logic [FIFO_PTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[rtl/bd4_front.sv]
// front part: config registers, pixel intake, position tracking, horizontal sums
// depends on bd4_pkg; feeds bd4_fifo
`timescale 1ns / 1ps

module bd4_front
    import bd4_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 1024,
    parameter int IDXW          = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [0:0]       wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] pixel_value,
    input  logic             q_full,
    output logic             q_push,
    output logic [IDXW-1:0]  q_idx,
    output blk_op_t          q_op
);

    localparam int COLW = $clog2(MAX_ROW_BYTES);
    localparam int CMPA = $clog2(MAX_ROW_BYTES + 1);
    localparam int CMPW = (CMPA > CFG_W) ? CMPA : CFG_W;

    logic [CFG_W-1:0]  row_bytes_reg;
    logic [CFG_W-1:0]  image_rows_reg;
    logic [COLW-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [HSUM_W-1:0] hpart_reg, hpart_next;

    logic [CMPW-1:0]   rb_ext;
    logic [CMPW-1:0]   wclamp;
    logic [CMPW-1:0]   width;
    logic [CMPW-1:0]   col_plus;
    logic [CFG_W-1:0]  rclamp;
    logic [CFG_W-1:0]  rows;
    logic [CFG_W-1:0]  row_plus;
    logic              row_end;
    logic              frame_end;
    logic              group_end;
    logic              accept;
    logic [HSUM_W-1:0] hsum;

    // effective width and row count: clamp then round down to multiple of four
    always_comb
    begin
        rb_ext = CMPW'(row_bytes_reg);
        if (rb_ext < CMPW'(MIN_DIM))
        begin
            wclamp = CMPW'(MIN_DIM);
        end
        else if (rb_ext > CMPW'(MAX_ROW_BYTES))
        begin
            wclamp = CMPW'(MAX_ROW_BYTES);
        end
        else
        begin
            wclamp = rb_ext;
        end
        width = {wclamp[CMPW-1:2], 2'b00};

        if (image_rows_reg < MIN_DIM)
        begin
            rclamp = MIN_DIM;
        end
        else if (image_rows_reg > ROW_LIMIT)
        begin
            rclamp = ROW_LIMIT;
        end
        else
        begin
            rclamp = image_rows_reg;
        end
        rows = {rclamp[CFG_W-1:2], 2'b00};
    end

    assign col_plus  = CMPW'(col_reg) + CMPW'(1);
    assign row_plus  = CFG_W'(row_reg) + CFG_W'(1);
    assign row_end   = (col_plus >= width);
    assign frame_end = (row_plus >= rows);
    assign group_end = (col_reg[1:0] == 2'b11);

    // only the fourth pixel of a group needs room in the queue
    assign in_ready = !q_full || !group_end;
    assign accept   = in_valid && in_ready;
    assign hsum     = hpart_reg + HSUM_W'(pixel_value);

    assign q_push            = accept && group_end;
    assign q_idx             = col_reg[COLW-1:2];
    assign q_op.first_row    = (row_reg[1:0] == 2'b00);
    assign q_op.emit         = (row_reg[1:0] == 2'b11);
    assign q_op.end_row      = row_end;
    assign q_op.end_frame    = row_end && frame_end;
    assign q_op.hsum         = hsum;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        hpart_next = hpart_reg;
        if (accept)
        begin
            hpart_next = (group_end || row_end) ? '0 : hsum;
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= RESET_DIM;
            image_rows_reg <= RESET_DIM;
            col_reg        <= '0;
            row_reg        <= '0;
            hpart_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_ROW_BYTES:  row_bytes_reg  <= wr_data;
                    REG_IMAGE_ROWS: image_rows_reg <= wr_data;
                    default:        row_bytes_reg  <= row_bytes_reg;
                endcase
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            hpart_reg <= hpart_next;
        end
    end

endmodule

[rtl/bd4_back.sv]
// back part: column accumulator store, read-modify-write and result register
// depends on bd4_pkg; drained from bd4_fifo
`timescale 1ns / 1ps

module bd4_back
    import bd4_pkg::*;
#(
    parameter int IDXW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [IDXW-1:0]  q_idx,
    input  blk_op_t          q_op,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] block_sum,
    output logic             end_of_block_row,
    output logic             end_of_frame
);

    localparam int BLOCK_COLS = 1 << IDXW;

    logic [SUM_W-1:0]      acc_mem [BLOCK_COLS];
    logic [BLOCK_COLS-1:0] vld_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic [IDXW-1:0]  s1_idx_reg;
    blk_op_t          s1_op_reg;
    logic             s1_hit_reg;
    logic             s1_fwd_reg;
    logic [SUM_W-1:0] s1_fwd_data_reg;
    logic [SUM_W-1:0] rd_data_reg;

    logic             out_valid_reg;
    logic [SUM_W-1:0] block_sum_reg;
    logic             eobr_reg;
    logic             eof_reg;

    logic             adv;
    logic             wr;
    logic             fwd_hit;
    logic [SUM_W-1:0] old_val;
    logic [SUM_W-1:0] new_val;

    // stage one may finish unless it holds a result the output cannot take
    assign adv     = !s1_valid_reg || !s1_op_reg.emit || !out_valid_reg || out_ready;
    assign q_pop   = !q_empty && adv;
    assign wr      = s1_valid_reg && adv;
    // write in flight to the address being read: forward it
    assign fwd_hit = wr && (s1_idx_reg == q_idx);

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            old_val = s1_fwd_data_reg;
        end
        else if (s1_hit_reg)
        begin
            old_val = rd_data_reg;
        end
        else
        begin
            old_val = '0;
        end
        new_val = s1_op_reg.first_row ? SUM_W'(s1_op_reg.hsum)
                                      : old_val + SUM_W'(s1_op_reg.hsum);
        s1_valid_next = q_pop ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            acc_mem[s1_idx_reg] <= new_val;
        end
        if (q_pop)
        begin
            rd_data_reg <= acc_mem[q_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (wr)
            begin
                vld_reg[s1_idx_reg] <= 1'b1;
            end
            if (wr && s1_op_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_idx_reg      <= q_idx;
            s1_op_reg       <= q_op;
            s1_hit_reg      <= vld_reg[q_idx];
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= new_val;
        end
        if (wr && s1_op_reg.emit)
        begin
            block_sum_reg <= new_val;
            eobr_reg      <= s1_op_reg.end_row;
            eof_reg       <= s1_op_reg.end_frame;
        end
    end

    assign out_valid        = out_valid_reg;
    assign block_sum        = block_sum_reg;
    assign end_of_block_row = eobr_reg;
    assign end_of_frame     = eof_reg;

endmodule

[rtl/box_downsample_4x4.sv]
// 4x4 box downsampler (average pooling) of an 8-bit grayscale pixel stream
// top level; depends on bd4_pkg, bd4_front, bd4_fifo, bd4_back
//
// pixels enter on in_valid/in_ready in raster order, one word per pixel;
// one block_sum word leaves on out_valid/out_ready per 4x4 block, with
// end_of_block_row and end_of_frame flags; block_sum/4080 is the mean in 0..1
// row_bytes and image_rows are set through wr_en/wr_index/wr_data while idle
// throughput: one pixel per cycle while the queue has room at a group's last
// pixel; the accumulator store does one read and one write per four-pixel
// group, so it never limits the rate; a result becomes valid once the last
// pixel of its block has passed the queue, the store read and the update
// the receiver may stall freely: results wait in the output register, the
// four-entry queue fills, and in_ready drops only on the last pixel of a group
// reset clears positions, partial sums, accumulator valid bits and all
// handshake state; registers return to 28 x 28; no clearing pass is needed
`timescale 1ns / 1ps

module box_downsample_4x4
    import bd4_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [0:0]       wr_index,
    input  logic [CFG_W-1:0] wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] pixel_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] block_sum,
    output logic             end_of_block_row,
    output logic             end_of_frame
);

    localparam int IDXW = $clog2(MAX_ROW_BYTES) - 2;
    localparam int QW   = IDXW + $bits(blk_op_t);

    logic            push;
    logic [IDXW-1:0] push_idx;
    blk_op_t         push_op;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QW-1:0]   q_rdata;
    logic [IDXW-1:0] pop_idx;
    blk_op_t         pop_op;

    bd4_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .IDXW          (IDXW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .q_full      (q_full),
        .q_push      (push),
        .q_idx       (push_idx),
        .q_op        (push_op)
    );

    bd4_fifo #(
        .DW (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({push_idx, push_op}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign pop_idx = q_rdata[QW-1 -: IDXW];
    assign pop_op  = q_rdata[$bits(blk_op_t)-1:0];

    bd4_back #(
        .IDXW (IDXW)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_idx            (pop_idx),
        .q_op             (pop_op),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .block_sum        (block_sum),
        .end_of_block_row (end_of_block_row),
        .end_of_frame     (end_of_frame)
    );

endmodule

[rtl/bd4_checker.sv]
// port-level checks for box_downsample_4x4, attached by bind
// depends on bd4_pkg and box_downsample_4x4_assert.svh
`timescale 1ns / 1ps

`include "box_downsample_4x4_assert.svh"

module bd4_checker
    import bd4_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SUM_W-1:0] block_sum,
    input logic             end_of_block_row,
    input logic             end_of_frame
);

    // a stalled result word holds its value
    `BD4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(block_sum) && $stable(end_of_frame), "result changed while stalled")

    // the last block of a frame also closes its block row
    `BD4_ASSERT_NOW(a_eof_row, clk, rst_n, out_valid && end_of_frame, end_of_block_row, "frame end without block row end")

    // nothing is offered in the first cycle after reset
    `BD4_ASSERT_NOW(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_valid, "result right after reset")

endmodule

bind box_downsample_4x4 bd4_checker u_bd4_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .block_sum        (block_sum),
    .end_of_block_row (end_of_block_row),
    .end_of_frame     (end_of_frame)
);
